// ===== rtl/slf_pkg.sv =====
// ----------------------------------------------------------------------------
// slf_pkg
// Shared types, register indexes and helpers for the link force unit.
// ----------------------------------------------------------------------------
package slf_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 32;

	localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ADHESION  = 2'd2;

	localparam logic [CFG_DATA_W-1:0] STIFFNESS_RST = 32'h0001_0000;
	localparam logic [CFG_DATA_W-1:0] DAMPING_RST   = 32'h0000_0000;
	localparam logic [CFG_DATA_W-1:0] ADHESION_RST  = 32'h0001_0000;

	localparam logic [1:0] CMD_SPRING = 2'd0;
	localparam logic [1:0] CMD_DAMPER = 2'd1;
	localparam logic [1:0] CMD_DAMPED = 2'd2;
	localparam logic [1:0] CMD_COND   = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [30:0]        rest_length;
		logic signed [31:0] dpos_x;
		logic signed [31:0] dpos_y;
		logic signed [31:0] dpos_z;
		logic signed [31:0] dvel_x;
		logic signed [31:0] dvel_y;
		logic signed [31:0] dvel_z;
	} link_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic               skipped;
	} res_t;

	// magnitude of a two's complement word, most negative value included
	function automatic logic [31:0] mag32(input logic [31:0] a);
		return a[31] ? (~a + 32'd1) : a;
	endfunction

endpackage

// ===== rtl/spring_damper_link_force_unit.sv =====
// ----------------------------------------------------------------------------
// spring_damper_link_force_unit
// Force of one mass-spring link on its second mass, Q16.16 by default.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is taken every cycle while results are being
// taken. The pipeline depth is set by the square root, which resolves one
// distance bit per stage over 32 stages, and by the direction divider, which
// resolves one quotient bit per stage over FRAC_BITS + 1 stages; the rest is
// a squaring stage, a summing stage and six multiply and select stages. When
// a result is not taken, the whole pipeline holds and link_ready drops.
// Configuration writes take effect at once and are meant for when no items
// are in flight.
module spring_damper_link_force_unit
	import slf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  link_valid,
	output logic                  link_ready,
	input  link_t                 link,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res
);

	logic [CFG_DATA_W-1:0] stiffness_q, damping_q, adhesion_q;
	logic                  en;
	logic                  sq_valid;
	logic [31:0]           sq_dist;
	link_t                 sq_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= STIFFNESS_RST;
			damping_q   <= DAMPING_RST;
			adhesion_q  <= ADHESION_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_STIFFNESS: stiffness_q <= cfg_wdata;
				REG_DAMPING:   damping_q   <= cfg_wdata;
				REG_ADHESION:  adhesion_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline moves while the output slot is empty or being drained
	assign en         = !res_valid || res_ready;
	assign link_ready = en;

	slf_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (link_valid),
		.in_item   (link),
		.out_valid (sq_valid),
		.distance  (sq_dist),
		.out_item  (sq_item)
	);

	slf_force #(
		.FRAC_BITS (FRAC_BITS)
	) u_force (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (sq_valid),
		.distance       (sq_dist),
		.in_item        (sq_item),
		.stiffness      (stiffness_q),
		.damping        (damping_q),
		.adhesion_ratio (adhesion_q),
		.out_valid      (res_valid),
		.res            (res)
	);

endmodule

// ===== rtl/slf_sqrt.sv =====
// ----------------------------------------------------------------------------
// slf_sqrt
// Sum of squares of the position difference and a pipelined integer square
// root, one result bit per stage.
// ----------------------------------------------------------------------------
module slf_sqrt
	import slf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  link_t       in_item,
	output logic        out_valid,
	output logic [31:0] distance,
	output link_t       out_item
);

	localparam int STEPS = 32;

	logic [31:0] mx, my, mz;
	logic [63:0] sqx_s1, sqy_s1, sqz_s1;
	link_t       item_s1;
	logic        valid_s1;

	logic [63:0] rem_s  [STEPS+1];
	logic [63:0] root_s [STEPS+1];
	link_t       itm_s  [STEPS+1];
	logic        vld_s  [STEPS+1];

	assign mx = mag32(in_item.dpos_x);
	assign my = mag32(in_item.dpos_y);
	assign mz = mag32(in_item.dpos_z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			vld_s[0] <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			vld_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s1    <= mx * mx;
			sqy_s1    <= my * my;
			sqz_s1    <= mz * mz;
			item_s1   <= in_item;
			// three squares of at most 2^62 each stay below 2^64
			rem_s[0]  <= sqx_s1 + sqy_s1 + sqz_s1;
			root_s[0] <= 64'd0;
			itm_s[0]  <= item_s1;
		end
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
		logic [64:0] trial;
		logic        take;

		always_comb begin
			trial = {1'b0, root_s[g]} + {1'b0, BIT};
			take  = {1'b0, rem_s[g]} >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				itm_s[g+1] <= itm_s[g];
				if (take) begin
					rem_s[g+1]  <= rem_s[g] - trial[63:0];
					root_s[g+1] <= (root_s[g] >> 1) + BIT;
				end else begin
					rem_s[g+1]  <= rem_s[g];
					root_s[g+1] <= root_s[g] >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign distance  = root_s[STEPS][31:0];
	assign out_item  = itm_s[STEPS];

endmodule

// ===== rtl/slf_div.sv =====
// ----------------------------------------------------------------------------
// slf_div
// Three-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage, computing (a << (QW-1)) / d for a <= d.
// ----------------------------------------------------------------------------
module slf_div #(
	parameter int QW = 17,
	parameter int SW = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [31:0]         dvsr,
	input  logic [2:0][31:0]    dvnd,
	input  logic [SW-1:0]       in_side,
	output logic                out_valid,
	output logic [2:0][QW-1:0]  quo,
	output logic [SW-1:0]       out_side
);

	logic [31:0]        dvsr_s [QW];
	logic [2:0][31:0]   rem_s  [QW];
	logic [2:0][QW-1:0] quo_s  [QW];
	logic [SW-1:0]      side_s [QW];
	logic               vld_s  [QW];

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic [31:0]        d_in;
		logic [2:0][31:0]   r_in;
		logic [2:0][QW-1:0] q_in;
		logic [SW-1:0]      s_in;
		logic               v_in;
		logic [2:0][32:0]   part;
		logic [2:0]         ge;
		logic [2:0][31:0]   rnext;
		logic [2:0][QW-1:0] qnext;

		if (g == 0) begin : g_first
			assign d_in = dvsr;
			assign r_in = dvnd;
			assign q_in = '0;
			assign s_in = in_side;
			assign v_in = in_valid;
		end else begin : g_next
			assign d_in = dvsr_s[g-1];
			assign r_in = rem_s[g-1];
			assign q_in = quo_s[g-1];
			assign s_in = side_s[g-1];
			assign v_in = vld_s[g-1];
		end

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				// first stage tests the integer bit, later ones shift in a zero
				part[l]  = (g == 0) ? {1'b0, r_in[l]} : {r_in[l], 1'b0};
				ge[l]    = part[l] >= {1'b0, d_in};
				rnext[l] = ge[l] ? 32'(part[l] - {1'b0, d_in}) : part[l][31:0];
				qnext[l] = {q_in[l][QW-2:0], ge[l]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dvsr_s[g] <= d_in;
				rem_s[g]  <= rnext;
				quo_s[g]  <= qnext;
				side_s[g] <= s_in;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quo       = quo_s[QW-1];
	assign out_side  = side_s[QW-1];

endmodule

// ===== rtl/slf_force.sv =====
// ----------------------------------------------------------------------------
// slf_force
// Link law arithmetic: spring, reach and damping products, the unit
// direction through the divider, projection and final saturation.
// ----------------------------------------------------------------------------
module slf_force
	import slf_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [31:0] distance,
	input  link_t       in_item,
	input  logic [31:0] stiffness,
	input  logic [31:0] damping,
	input  logic [31:0] adhesion_ratio,
	output logic        out_valid,
	output res_t        res
);

	localparam int F   = FRAC_BITS;
	localparam int QW  = F + 1;
	localparam int SPW = 65 - F;
	localparam int RCW = 63 - F;
	localparam int ZVW = 64 - F;
	localparam int DPW = 66 - F;
	localparam int TW  = 68 - F;
	localparam logic signed [TW-1:0] MAXV = TW'(32'sh7FFF_FFFF);
	localparam logic signed [TW-1:0] MINV = TW'(32'sh8000_0000);

	typedef struct packed {
		logic [1:0]           cmd;
		logic                 skip;
		logic [SPW-1:0]       spring_mag;
		logic                 spring_neg;
		logic [2:0][ZVW-1:0]  zv_mag;
		logic [2:0]           zv_neg;
		logic [2:0][31:0]     vmag;
		logic [2:0]           vneg;
		logic [2:0]           pneg;
	} mid_t;

	function automatic logic signed [31:0] sat32(input logic signed [TW-1:0] v);
		logic signed [TW-1:0] r;
		r = v;
		if (v > MAXV) begin
			r = MAXV;
		end else if (v < MINV) begin
			r = MINV;
		end
		return r[31:0];
	endfunction

	// ---------------- stage 1: products ahead of the divider
	logic signed [33:0]   dl;
	logic [32:0]          dl_mag;
	logic [64:0]          spring_prod;
	logic [62:0]          reach_prod;
	logic [2:0][31:0]     pmag, vmag;
	logic [2:0]           pneg, vneg;
	logic [2:0][63:0]     zv_prod;

	logic                 valid_s1;
	logic [31:0]          dist_s1;
	logic [1:0]           cmd_s1;
	logic [SPW-1:0]       spring_s1;
	logic                 spring_neg_s1;
	logic [RCW-1:0]       reach_s1;
	logic [2:0][ZVW-1:0]  zv_s1;
	logic [2:0][31:0]     pmag_s1, vmag_s1;
	logic [2:0]           pneg_s1, vneg_s1;

	always_comb begin
		pmag[0] = mag32(in_item.dpos_x);
		pmag[1] = mag32(in_item.dpos_y);
		pmag[2] = mag32(in_item.dpos_z);
		pneg    = {in_item.dpos_z[31], in_item.dpos_y[31], in_item.dpos_x[31]};
		vmag[0] = mag32(in_item.dvel_x);
		vmag[1] = mag32(in_item.dvel_y);
		vmag[2] = mag32(in_item.dvel_z);
		vneg    = {in_item.dvel_z[31], in_item.dvel_y[31], in_item.dvel_x[31]};
		dl      = $signed({2'b00, distance}) - $signed({3'b000, in_item.rest_length});
		dl_mag  = dl[33] ? 33'(-dl) : dl[32:0];
		spring_prod = stiffness * dl_mag;
		reach_prod  = adhesion_ratio * in_item.rest_length;
		for (int i = 0; i < 3; i++) begin
			zv_prod[i] = damping * vmag[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s1       <= distance;
			cmd_s1        <= in_item.cmd;
			spring_s1     <= SPW'(spring_prod >> F);
			spring_neg_s1 <= dl[33];
			reach_s1      <= RCW'(reach_prod >> F);
			for (int i = 0; i < 3; i++) begin
				zv_s1[i] <= ZVW'(zv_prod[i] >> F);
			end
			pmag_s1 <= pmag;
			pneg_s1 <= pneg;
			vmag_s1 <= vmag;
			vneg_s1 <= vneg;
		end
	end

	// ---------------- unit direction
	mid_t             side_in, side_out;
	logic             div_valid;
	logic [2:0][QW-1:0] umag;

	always_comb begin
		side_in.cmd        = cmd_s1;
		// out of reach for the conditional law, or no direction at all
		side_in.skip       = ((cmd_s1 == CMD_COND) && (RCW'(dist_s1) > reach_s1))
			|| (dist_s1 == 32'd0);
		side_in.spring_mag = spring_s1;
		side_in.spring_neg = spring_neg_s1;
		side_in.zv_mag     = zv_s1;
		side_in.zv_neg     = vneg_s1;
		side_in.vmag       = vmag_s1;
		side_in.vneg       = vneg_s1;
		side_in.pneg       = pneg_s1;
	end

	slf_div #(
		.QW (QW),
		.SW ($bits(mid_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s1),
		.dvsr      (dist_s1),
		.dvnd      (pmag_s1),
		.in_side   (side_in),
		.out_valid (div_valid),
		.quo       (umag),
		.out_side  (side_out)
	);

	// ---------------- stage 2: projections onto the direction
	logic                 valid_s2;
	mid_t                 mid_s2;
	logic [2:0][QW-1:0]   umag_s2;
	logic [2:0][SPW-1:0]  t1_mag_s2;
	logic [2:0]           t1_neg_s2;
	logic signed [32:0]   vu_s2 [3];
	logic [2:0][SPW+QW-1:0] t1_prod;
	logic [2:0][32+QW-1:0]  vu_prod;
	logic [2:0][31:0]       vu_mag;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t1_prod[i] = side_out.spring_mag * umag[i];
			vu_prod[i] = side_out.vmag[i] * umag[i];
			vu_mag[i]  = 32'(vu_prod[i] >> F);
		end
	end

	// ---------------- stage 3: normal velocity sum and spring term
	logic                 valid_s3;
	logic [1:0]           cmd_s3;
	logic                 skip_s3;
	logic [2:0][QW-1:0]   umag_s3;
	logic [2:0]           pneg_s3;
	logic signed [34:0]   vn_s3;
	logic signed [TW-1:0] sterm_s3 [3];
	logic signed [TW-1:0] t1_sig [3];
	logic signed [TW-1:0] zv_sig [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			t1_sig[i] = t1_neg_s2[i] ? -$signed(TW'(t1_mag_s2[i]))
				: $signed(TW'(t1_mag_s2[i]));
			if (mid_s2.cmd == CMD_SPRING) begin
				zv_sig[i] = '0;
			end else begin
				zv_sig[i] = mid_s2.zv_neg[i] ? -$signed(TW'(mid_s2.zv_mag[i]))
					: $signed(TW'(mid_s2.zv_mag[i]));
			end
		end
	end

	// ---------------- stage 4: damping scalar
	logic                 valid_s4;
	logic [1:0]           cmd_s4;
	logic                 skip_s4;
	logic [2:0][QW-1:0]   umag_s4;
	logic [2:0]           pneg_s4;
	logic signed [TW-1:0] sterm_s4 [3];
	logic [DPW-1:0]       damp_mag_s4;
	logic                 damp_neg_s4;
	logic [33:0]          vn_mag;
	logic [65:0]          damp_prod;

	always_comb begin
		vn_mag    = vn_s3[34] ? 34'(-vn_s3) : 34'(vn_s3);
		damp_prod = damping * vn_mag;
	end

	// ---------------- stage 5: damper term along the direction
	logic                 valid_s5;
	logic [1:0]           cmd_s5;
	logic                 skip_s5;
	logic signed [TW-1:0] sterm_s5 [3];
	logic [2:0][DPW-1:0]  dterm_mag_s5;
	logic [2:0]           dterm_neg_s5;
	logic [2:0][DPW+QW-1:0] dprod;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dprod[i] = damp_mag_s4 * umag_s4[i];
		end
	end

	// ---------------- stage 6: law select, negate, saturate
	logic                 valid_s6;
	res_t                 res_s6;
	logic signed [TW-1:0] fsum [3];
	res_t                 res_next;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (cmd_s5 == CMD_DAMPER) begin
				fsum[i] = dterm_neg_s5[i] ? $signed(TW'(dterm_mag_s5[i]))
					: -$signed(TW'(dterm_mag_s5[i]));
			end else begin
				fsum[i] = -sterm_s5[i];
			end
		end
		res_next.force_x = skip_s5 ? 32'sd0 : sat32(fsum[0]);
		res_next.force_y = skip_s5 ? 32'sd0 : sat32(fsum[1]);
		res_next.force_z = skip_s5 ? 32'sd0 : sat32(fsum[2]);
		res_next.skipped = skip_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s2 <= div_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s2  <= side_out;
			umag_s2 <= umag;
			for (int i = 0; i < 3; i++) begin
				t1_mag_s2[i] <= SPW'(t1_prod[i] >> F);
				t1_neg_s2[i] <= side_out.spring_neg ^ side_out.pneg[i];
				vu_s2[i]     <= (side_out.vneg[i] ^ side_out.pneg[i])
					? -$signed({1'b0, vu_mag[i]}) : $signed({1'b0, vu_mag[i]});
			end

			cmd_s3  <= mid_s2.cmd;
			skip_s3 <= mid_s2.skip;
			umag_s3 <= umag_s2;
			pneg_s3 <= mid_s2.pneg;
			vn_s3   <= 35'(vu_s2[0]) + 35'(vu_s2[1]) + 35'(vu_s2[2]);
			for (int i = 0; i < 3; i++) begin
				sterm_s3[i] <= t1_sig[i] + zv_sig[i];
			end

			cmd_s4      <= cmd_s3;
			skip_s4     <= skip_s3;
			umag_s4     <= umag_s3;
			pneg_s4     <= pneg_s3;
			sterm_s4    <= sterm_s3;
			damp_mag_s4 <= DPW'(damp_prod >> F);
			damp_neg_s4 <= vn_s3[34];

			cmd_s5   <= cmd_s4;
			skip_s5  <= skip_s4;
			sterm_s5 <= sterm_s4;
			for (int i = 0; i < 3; i++) begin
				dterm_mag_s5[i] <= DPW'(dprod[i] >> F);
				dterm_neg_s5[i] <= damp_neg_s4 ^ pneg_s4[i];
			end

			res_s6 <= res_next;
		end
	end

	assign out_valid = valid_s6;
	assign res       = res_s6;

endmodule

// ===== rtl/slf_checker.sv =====
// ----------------------------------------------------------------------------
// slf_checker
// Port-level checks for the link force unit, bound to the top level.
// ----------------------------------------------------------------------------
module slf_checker
	import slf_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  link_valid,
	input logic  link_ready,
	input logic  res_valid,
	input logic  res_ready,
	input res_t  res
);

	// a stalled result stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	// input side only blocks when a result is waiting
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		link_ready == (!res_valid || res_ready))
		else $error("link_ready does not follow the output slot");

	// a skipped link carries no force
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.skipped |->
			res.force_x == 32'sd0 && res.force_y == 32'sd0 && res.force_z == 32'sd0)
		else $error("skipped item with nonzero force");

endmodule

bind spring_damper_link_force_unit slf_checker u_slf_checker (.*);

// ===== sim/tb_spring_damper_link_force_unit.sv =====
// ----------------------------------------------------------------------------
// tb_spring_damper_link_force_unit
// Drives link items through the force unit under several idle and stall
// patterns and register settings, and checks each force against a predictor.
// ----------------------------------------------------------------------------
module tb_spring_damper_link_force_unit;
	import slf_pkg::*;

	localparam int FB        = 16;
	localparam int LATENCY   = FB + 41;
	localparam longint LIMIT = 400000;
	localparam longint PSAT  = 64'sd1 << 61;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic link_valid = 1'b0;
	logic link_ready;
	link_t link = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycles = 0;

	spring_damper_link_force_unit #(.FRAC_BITS(FB)) dut (.*);

	always #5 clk = ~clk;

	// exact product shifted down with magnitude truncated, clamped to +-2^61
	function automatic longint fx_mul(longint a, longint b);
		logic [63:0] ua, ub;
		logic [127:0] p;
		logic [127:0] r;
		longint m;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		p = ua * ub;
		r = p >> FB;
		m = (r > 128'(PSAT)) ? PSAT : longint'(r);
		return ((a < 0) != (b < 0)) ? -m : m;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [65:0] num);
		logic [65:0] rem, res_v, bit_v;
		rem = num;
		res_v = '0;
		bit_v = 66'd1 << 64;
		while (bit_v > rem) bit_v >>= 2;
		while (bit_v != 0) begin
			if (rem >= res_v + bit_v) begin
				rem -= res_v + bit_v;
				res_v = (res_v >> 1) + bit_v;
			end else begin
				res_v >>= 1;
			end
			bit_v >>= 2;
		end
		return res_v[63:0];
	endfunction

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	class force_scoreboard;
		logic [31:0] k_reg, z_reg, s_reg;
		res_t pending[$];
		int mismatches;

		function new();
			k_reg = STIFFNESS_RST;
			z_reg = DAMPING_RST;
			s_reg = ADHESION_RST;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
			if (idx == REG_STIFFNESS) k_reg = val;
			else if (idx == REG_DAMPING) z_reg = val;
			else if (idx == REG_ADHESION) s_reg = val;
		endfunction

		function void note_link(link_t it);
			longint p[3], v[3], u[3], f[3];
			logic [65:0] sq;
			longint d, l0, k, z, spring, vn, damp, t;
			logic [63:0] q;
			logic skip;
			res_t e;
			p[0] = longint'(it.dpos_x); p[1] = longint'(it.dpos_y);
			p[2] = longint'(it.dpos_z);
			v[0] = longint'(it.dvel_x); v[1] = longint'(it.dvel_y);
			v[2] = longint'(it.dvel_z);
			sq = '0;
			for (int i = 0; i < 3; i++) begin
				q = p[i] < 0 ? -p[i] : p[i];
				sq += 66'(q) * 66'(q);
			end
			d = int_sqrt(sq);
			l0 = longint'(it.rest_length);
			k = longint'(k_reg);
			z = longint'(z_reg);
			f = '{0, 0, 0};
			skip = (it.cmd == CMD_COND && d > fx_mul(longint'(s_reg), l0)) || d == 0;
			if (!skip) begin
				for (int i = 0; i < 3; i++) begin
					q = ((p[i] < 0 ? -p[i] : p[i]) << FB) / d;
					u[i] = p[i] < 0 ? -longint'(q) : longint'(q);
				end
				if (it.cmd == CMD_DAMPER) begin
					vn = 0;
					for (int i = 0; i < 3; i++) vn += fx_mul(v[i], u[i]);
					damp = fx_mul(z, vn);
					for (int i = 0; i < 3; i++) f[i] = -fx_mul(damp, u[i]);
				end else begin
					spring = fx_mul(k, d - l0);
					for (int i = 0; i < 3; i++) begin
						t = fx_mul(spring, u[i]);
						if (it.cmd != CMD_SPRING) t += fx_mul(z, v[i]);
						f[i] = -t;
					end
				end
			end
			e.force_x = sat32(f[0]);
			e.force_y = sat32(f[1]);
			e.force_z = sat32(f[2]);
			e.skipped = skip;
			pending.push_back(e);
		endfunction

		function void check_force(res_t got);
			res_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				mismatches++;
				if (mismatches <= 10) $display("force mismatch: expected %p got %p", e, got);
			end
		endfunction
	endclass

	force_scoreboard sb = new();

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && res_valid && res_ready) sb.check_force(res);
		if (arst_n && link_valid && link_ready) sb.note_link(link);
	end

	always @(negedge clk)
		res_ready <= ($urandom_range(99) >= recv_stall_pct);

	// valid stays up after the accept so back to back items need no gap;
	// idling and draining drop it
	task automatic send_link(link_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			link_valid <= 1'b0;
			@(negedge clk);
		end
		link_valid <= 1'b1;
		link <= it;
		@(posedge clk);
		while (!link_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		link_valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		drain();
		repeat (LATENCY + 4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
			2: return 32'($signed($urandom_range(2 * 65536 * 4)) - 65536 * 4);
			default: return $urandom_range(1) ? 32'h80000000 : 32'h7fffffff;
		endcase
	endfunction

	function automatic link_t rand_link();
		link_t it;
		it.cmd = 2'($urandom_range(3));
		it.rest_length = $urandom_range(1) ? 31'($urandom) : 31'($urandom_range(65536 * 64));
		it.dpos_x = rand_coord(); it.dpos_y = rand_coord(); it.dpos_z = rand_coord();
		it.dvel_x = rand_coord(); it.dvel_y = rand_coord(); it.dvel_z = rand_coord();
		if ($urandom_range(19) == 0) begin
			it.dpos_x = '0; it.dpos_y = '0; it.dpos_z = '0;
		end
		return it;
	endfunction

	function automatic link_t mk(logic [1:0] c, logic [30:0] l, logic [31:0] px,
			logic [31:0] py, logic [31:0] pz, logic [31:0] vx, logic [31:0] vy,
			logic [31:0] vz);
		link_t it;
		it.cmd = c; it.rest_length = l;
		it.dpos_x = px; it.dpos_y = py; it.dpos_z = pz;
		it.dvel_x = vx; it.dvel_y = vy; it.dvel_z = vz;
		return it;
	endfunction

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero distance, extremes, every law, reach edge
		write_reg(REG_DAMPING, 32'h0000_8000);
		for (int c = 0; c < 4; c++) begin
			send_link(mk(2'(c), 31'h10000, 0, 0, 0, 32'h10000, 0, 0));
			send_link(mk(2'(c), 31'h20000, 32'h30000, 32'h40000, 0, 32'h10000,
				32'hffff0000, 32'h8000));
			send_link(mk(2'(c), 31'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
				32'h80000000, 32'h7fffffff, 32'h80000000));
			send_link(mk(2'(c), 31'd0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
				32'h7fffffff, 32'h80000000, 32'h7fffffff));
		end
		// distance exactly at reach, then just beyond
		send_link(mk(CMD_COND, 31'h50000, 32'h30000, 32'h40000, 0, 1, 2, 3));
		send_link(mk(CMD_COND, 31'h4ffff, 32'h30000, 32'h40000, 0, 1, 2, 3));
		send_link(mk(CMD_COND, 31'd0, 1, 0, 0, 0, 0, 0));
		send_link(mk(CMD_SPRING, 31'd0, 1, 0, 0, 0, 0, 0));

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 65; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 65; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			case (ph)
				0: write_reg(REG_STIFFNESS, 32'hffffffff);
				1: write_reg(REG_DAMPING, 32'hffffffff);
				2: write_reg(REG_ADHESION, 32'hffffffff);
				3: write_reg(REG_STIFFNESS, 32'h0);
				4: write_reg(REG_ADHESION, 32'h0);
				5: write_reg(REG_DAMPING, 32'h0);
				default: begin
					write_reg(REG_STIFFNESS, $urandom);
					write_reg(REG_DAMPING, $urandom_range(1 << 20));
					write_reg(REG_ADHESION, $urandom_range(1 << 18));
				end
			endcase
			for (int n = 0; n < 48; n++) begin
				if (n == 24) drain();
				send_link(rand_link());
			end
		end

		drain();
		repeat (LATENCY + 10) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("PASS spring_damper_link_force_unit");
		else
			$display("FAIL spring_damper_link_force_unit");
		$finish;
	end

	always @(posedge clk)
		if (cycles > LIMIT) begin
			$display("FAIL spring_damper_link_force_unit");
			$finish;
		end

endmodule
